// File: rtl/core/py2rgb_pkg.sv
// py2rgb_pkg: shared types, layout codes and colour coefficients
package py2rgb_pkg;

  // packed layout codes of the byte order register
  localparam logic [1:0] ORDER_UYVY = 2'd0;
  localparam logic [1:0] ORDER_YUYV = 2'd1;
  localparam logic [1:0] ORDER_YVYU = 2'd2;

  // chroma scale factors, q8
  localparam logic signed [9:0] COEF_RV = 10'sd359;
  localparam logic signed [9:0] COEF_GU = 10'sd88;
  localparam logic signed [9:0] COEF_GV = 10'sd183;
  localparam logic signed [9:0] COEF_BU = 10'sd454;

  // width of the q8 intermediate sums
  localparam int unsigned SUM_W = 19;

  // one macropixel after unpacking, chroma already offset by -128
  typedef struct packed {
    logic        [7:0] y0;
    logic        [7:0] y1;
    logic signed [7:0] u;
    logic signed [7:0] v;
  } yuv_t;

endpackage

// File: rtl/core/packed_yuv422_to_rgb24_unit.sv
// packed_yuv422_to_rgb24_unit: packed 4:2:2 macropixel to two rgb24 pixels
// path: input register, then result register, from input transfer to result valid
// throughput: one macropixel per cycle while the result is not stalled, set by the two-stage register pipeline
// a full result stage holds while stalled and the input stage keeps taking items until both fill
// reset (rst_n, synchronous, low): both stages empty, byte order back to yuyv
// the configuration port is always ready and takes one write per cycle
module packed_yuv422_to_rgb24_unit (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_byte_order,
  // input macropixel channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte0,
  input  logic [7:0] in_byte1,
  input  logic [7:0] in_byte2,
  input  logic [7:0] in_byte3,
  input  logic       in_end_of_frame,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red0,
  output logic [7:0] out_green0,
  output logic [7:0] out_blue0,
  output logic [7:0] out_red1,
  output logic [7:0] out_green1,
  output logic [7:0] out_blue1,
  output logic       out_frame_done
);

  // configuration register
  logic [1:0] byte_order_r;

  // input stage: unpacked macropixel
  logic              s1_valid_r;
  py2rgb_pkg::yuv_t  s1_yuv_r;
  logic              s1_eof_r;
  py2rgb_pkg::yuv_t  yuv_nxt;

  // result stage
  logic       out_valid_r;
  logic [7:0] red0_nxt, green0_nxt, blue0_nxt;
  logic [7:0] red1_nxt, green1_nxt, blue1_nxt;
  logic [7:0] red0_r, green0_r, blue0_r;
  logic [7:0] red1_r, green1_r, blue1_r;
  logic       frame_done_r;

  // pipeline advance: a stage moves when the one after it is empty or moving
  logic s2_adv;
  logic s1_adv;

  assign s2_adv   = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= py2rgb_pkg::ORDER_YUYV;
    end else if (cfg_valid && cfg_ready) begin
      byte_order_r <= cfg_byte_order;
    end
  end

  // byte order decode ahead of the input register
  py2rgb_unpack u_unpack (
    .byte0      (in_byte0),
    .byte1      (in_byte1),
    .byte2      (in_byte2),
    .byte3      (in_byte3),
    .byte_order (byte_order_r),
    .yuv        (yuv_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload only loads on a transfer
  always_ff @(posedge clk) begin
    if (in_valid && s1_adv) begin
      s1_yuv_r <= yuv_nxt;
      s1_eof_r <= in_end_of_frame;
    end
  end

  // both pixels share the chroma pair
  py2rgb_pixel u_pixel0 (
    .luma  (s1_yuv_r.y0),
    .u     (s1_yuv_r.u),
    .v     (s1_yuv_r.v),
    .red   (red0_nxt),
    .green (green0_nxt),
    .blue  (blue0_nxt)
  );

  py2rgb_pixel u_pixel1 (
    .luma  (s1_yuv_r.y1),
    .u     (s1_yuv_r.u),
    .v     (s1_yuv_r.v),
    .red   (red1_nxt),
    .green (green1_nxt),
    .blue  (blue1_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_adv) begin
      red0_r       <= red0_nxt;
      green0_r     <= green0_nxt;
      blue0_r      <= blue0_nxt;
      red1_r       <= red1_nxt;
      green1_r     <= green1_nxt;
      blue1_r      <= blue1_nxt;
      frame_done_r <= s1_eof_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red0       = red0_r;
  assign out_green0     = green0_r;
  assign out_blue0      = blue0_r;
  assign out_red1       = red1_r;
  assign out_green1     = green1_r;
  assign out_blue1      = blue1_r;
  assign out_frame_done = frame_done_r;

`ifndef SYNTHESIS
  // an accepted macropixel always lands in the input stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted macropixel lost at input stage");

  // input stalls only when both stages are full and the result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  // a full input stage with an empty result stage moves into it on the next clock
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |=> out_valid_r)
    else $error("input stage failed to advance into empty result stage");
`endif

endmodule

// File: rtl/core/py2rgb_unpack.sv
// py2rgb_unpack: byte order decode of one packed 4:2:2 macropixel
module py2rgb_unpack (
  input  logic [7:0]        byte0,
  input  logic [7:0]        byte1,
  input  logic [7:0]        byte2,
  input  logic [7:0]        byte3,
  input  logic [1:0]        byte_order,
  output py2rgb_pkg::yuv_t  yuv
);

  logic [7:0] u_raw;
  logic [7:0] v_raw;

  always_comb begin
    unique case (byte_order)
      py2rgb_pkg::ORDER_UYVY: begin
        u_raw  = byte0;
        yuv.y0 = byte1;
        v_raw  = byte2;
        yuv.y1 = byte3;
      end
      py2rgb_pkg::ORDER_YVYU: begin
        yuv.y0 = byte0;
        v_raw  = byte1;
        yuv.y1 = byte2;
        u_raw  = byte3;
      end
      default: begin
        // yuyv, and the reserved code
        yuv.y0 = byte0;
        u_raw  = byte1;
        yuv.y1 = byte2;
        v_raw  = byte3;
      end
    endcase
    // minus 128 is a flip of the top bit into two's complement
    yuv.u = signed'({~u_raw[7], u_raw[6:0]});
    yuv.v = signed'({~v_raw[7], v_raw[6:0]});
  end

endmodule

// File: rtl/core/py2rgb_pixel.sv
// py2rgb_pixel: q8 colour matrix and clip for one pixel
module py2rgb_pixel (
  input  logic [7:0]        luma,
  input  logic signed [7:0] u,
  input  logic signed [7:0] v,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);

  localparam int unsigned W = py2rgb_pkg::SUM_W;

  logic signed [W-1:0] base;
  logic signed [W-1:0] rv_prod;
  logic signed [W-1:0] gu_prod;
  logic signed [W-1:0] gv_prod;
  logic signed [W-1:0] bu_prod;
  logic signed [W-1:0] r_sum;
  logic signed [W-1:0] g_sum;
  logic signed [W-1:0] b_sum;

  // floor shift by 8 is the upper slice; clip on sign and overflow bits
  function automatic logic [7:0] shift_clip(input logic signed [W-1:0] x);
    logic [W-9:0] s;
    s = x[W-1:8];
    if (s[W-9])
      return 8'd0;
    else if (|s[W-10:8])
      return 8'hFF;
    else
      return s[7:0];
  endfunction

  always_comb begin
    base    = signed'({{(W-16){1'b0}}, luma, 8'd0});
    rv_prod = py2rgb_pkg::COEF_RV * v;
    gu_prod = py2rgb_pkg::COEF_GU * u;
    gv_prod = py2rgb_pkg::COEF_GV * v;
    bu_prod = py2rgb_pkg::COEF_BU * u;
    r_sum   = base + rv_prod;
    g_sum   = base - gu_prod - gv_prod;
    b_sum   = base + bu_prod;
    red     = shift_clip(r_sum);
    green   = shift_clip(g_sum);
    blue    = shift_clip(b_sum);
  end

endmodule
